// ===== rtl/core/wfdc_pkg.sv =====
// Shared types, constants and the arctangent table of the wall-follow drive controller.
package wfdc_pkg;

   // Drive mode, also the code shown on the drive state output
   typedef enum logic [1:0] {
      MODE_TRACK    = 2'd0,
      MODE_CORNER   = 2'd1,
      MODE_AVOID    = 2'd2,
      MODE_FINISHED = 2'd3
   } drive_mode_type;

   // Distance band around the clearance target
   typedef enum logic [1:0] {
      BAND_IN    = 2'd0,
      BAND_CLOSE = 2'd1,
      BAND_FAR   = 2'd2
   } band_type;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_ROOT_GO,
      ST_ROOT,
      ST_DIV_GO,
      ST_DIV,
      ST_SCALE,
      ST_DECIDE,
      ST_RESP
   } seq_state_type;

   // Register indexes on the csr port
   localparam logic [3:0] CSR_CLEARANCE    = 4'd0;
   localparam logic [3:0] CSR_BAND_HALF    = 4'd1;
   localparam logic [3:0] CSR_HYST_MARGIN  = 4'd2;
   localparam logic [3:0] CSR_NOSE_STOP    = 4'd3;
   localparam logic [3:0] CSR_NOSE_CLEAR   = 4'd4;
   localparam logic [3:0] CSR_SIDE_NEAR    = 4'd5;
   localparam logic [3:0] CSR_GAP_MIN      = 4'd6;
   localparam logic [3:0] CSR_CORNER_TMO   = 4'd7;

   localparam int CFG_W     = 14;
   localparam int TMO_W     = 16;
   localparam int TH_W      = 22;   // heading angle, signed microradians
   localparam int ATAN_W    = 20;
   localparam int CORDIC_N  = 16;
   localparam int OPEN_W    = 7;
   localparam int MAG_W     = 25;   // 12*|theta| + 5000
   localparam int RECIP_W   = 16;
   localparam int RECIP_SH  = 29;

   localparam logic [OPEN_W-1:0]  OPEN_SAT      = 7'd100;
   localparam logic [16:0]        COS30_Q16X2   = 17'd113512;
   localparam logic [TH_W-2:0]    TOL_PARALLEL  = 21'd122173;
   localparam logic [TH_W-2:0]    TOL_REACQ     = 21'd174533;
   localparam logic [RECIP_W-1:0] RECIP_10000   = 16'd53687;
   localparam logic [MAG_W-1:0]   MAG_LIMIT_V   = 25'd6010000;
   localparam logic [MAG_W-1:0]   DEC_10000     = 25'd10000;
   localparam logic [MAG_W-1:0]   ROUND_5000    = 25'd5000;
   localparam logic [24:0]        CORDIC_X0     = 25'd21446656;   // 5236 * 4096

   // Output command values
   localparam logic [7:0]  LIN_STOP   = 8'd0;
   localparam logic [7:0]  LIN_AVOID  = 8'd140;
   localparam logic [7:0]  LIN_CORNER = 8'd160;
   localparam logic [7:0]  LIN_BAND   = 8'd120;
   localparam logic [7:0]  LIN_FULL   = 8'd200;
   localparam logic signed [10:0] ANG_ZERO    = 11'sd0;
   localparam logic signed [10:0] ANG_SEARCH  = 11'sd400;
   localparam logic signed [10:0] ANG_SPIN    = 11'sd600;
   localparam logic signed [10:0] ANG_CORNER  = -11'sd450;
   localparam logic signed [10:0] ANG_AWAY    = 11'sd300;
   localparam logic signed [10:0] ANG_TOWARD  = -11'sd300;
   localparam logic [9:0]         ANG_MAX     = 10'd600;

   // atan(2^-i) in microradians, rounded
   function automatic logic [ATAN_W-1:0] atan_urad(input logic [3:0] idx);
      logic [ATAN_W-1:0] val;
      case (idx)
         4'd0:    val = 20'd785398;
         4'd1:    val = 20'd463648;
         4'd2:    val = 20'd244979;
         4'd3:    val = 20'd124355;
         4'd4:    val = 20'd62419;
         4'd5:    val = 20'd31240;
         4'd6:    val = 20'd15624;
         4'd7:    val = 20'd7812;
         4'd8:    val = 20'd3906;
         4'd9:    val = 20'd1953;
         4'd10:   val = 20'd977;
         4'd11:   val = 20'd488;
         4'd12:   val = 20'd244;
         4'd13:   val = 20'd122;
         4'd14:   val = 20'd61;
         default: val = 20'd31;
      endcase
      return val;
   endfunction

endpackage

// ===== rtl/core/wfdc_sqrt.sv =====
// Iterative integer square root, one result bit per cycle.
module wfdc_sqrt #(
   parameter int VAL_W = 46
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [VAL_W-1:0]     value,
   output logic [VAL_W/2-1:0]   root,
   output logic                 done
);
   localparam int N   = VAL_W / 2;
   localparam int CNW = $clog2(N);

   logic [VAL_W-1:0] val_ff, val_in;
   logic [N+1:0]     rem_ff, rem_in;
   logic [N-1:0]     root_ff, root_in;
   logic [CNW-1:0]   cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [N+1:0]     rem_sh;
   logic [N+1:0]     trial;

   // one digit pair per cycle
   always_comb begin
      rem_sh  = {rem_ff[N-1:0], val_ff[VAL_W-1 -: 2]};
      trial   = {root_ff, 2'b01};
      val_in  = val_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         val_in  = value;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         val_in = val_ff << 2;
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[N-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[N-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNW'(N - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      val_ff  <= val_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign root = root_ff;
   assign done = done_ff;
endmodule

// ===== rtl/core/wfdc_div.sv =====
// Restoring divider, one quotient bit per cycle.
module wfdc_div #(
   parameter int NUM_W = 35,
   parameter int DEN_W = 23
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [NUM_W-1:0]  numer,
   input  logic [DEN_W-1:0]  denom,
   output logic [NUM_W-1:0]  quotient,
   output logic              done
);
   localparam int CNW = $clog2(NUM_W);

   logic [NUM_W-1:0] num_ff, num_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [CNW-1:0]   cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   rem_sh;

   // shift in one numerator bit, subtract if it fits
   always_comb begin
      rem_sh  = {rem_ff, num_ff[NUM_W-1]};
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         num_in  = numer;
         den_in  = denom;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in = DEN_W'(rem_sh - {1'b0, den_ff});
            num_in = {num_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[DEN_W-1:0];
            num_in = {num_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNW'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient = num_ff;
   assign done     = done_ff;
endmodule

// ===== rtl/core/wfdc_cordic.sv =====
// Vectoring CORDIC for the heading angle, one micro-rotation per cycle.
module wfdc_cordic #(
   parameter int DIFF_W = 15
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic signed [DIFF_W-1:0]        diff,
   output logic signed [wfdc_pkg::TH_W-1:0] theta
);
   import wfdc_pkg::*;

   localparam int XW = DIFF_W + 19;

   logic signed [XW-1:0]   x_ff, x_in;
   logic signed [XW-1:0]   y_ff, y_in;
   logic signed [TH_W-1:0] z_ff, z_in;
   logic [3:0]             idx_ff, idx_in;
   logic                   busy_ff, busy_in;
   logic signed [XW-1:0]   xs, ys, dx;
   logic signed [TH_W-1:0] ang;

   // rotate toward the x axis, accumulate the angle
   always_comb begin
      xs      = x_ff >>> idx_ff;
      ys      = y_ff >>> idx_ff;
      dx      = XW'(diff);
      ang     = signed'({2'b00, atan_urad(idx_ff)});
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      idx_in  = idx_ff;
      busy_in = busy_ff;
      if (start) begin
         x_in    = signed'(XW'(CORDIC_X0));
         y_in    = (dx <<< 15) + (dx <<< 13);
         z_in    = '0;
         idx_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!y_ff[XW-1]) begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + ang;
         end else begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - ang;
         end
         idx_in = idx_ff + 1'b1;
         if (idx_ff == 4'(CORDIC_N - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
      idx_ff <= idx_in;
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   assign theta = z_ff;
endmodule

// ===== rtl/core/wall_follow_drive_controller_core.sv =====
// Top level of the wall-follow drive controller: sequencer, shared multiplier, decision logic.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_ready  | front range, near ray, far ray, marker
//   rsp     | out       | rsp_valid/rsp_ready  | linear, angular, finished pulse, state
//   csr     | in        | csr_valid/csr_ready  | csr_index, csr_data (always ready)
//
// One request with valid rays takes 4 multiply steps, RANGE_BITS+9 root steps and
// 2*RANGE_BITS+7 divide steps plus the control states; the root and divide units
// set most of that time, and the CORDIC runs beside the root. A finished or
// invalid-ray request goes from idle straight to the decide state. req_ready is low
// until the response is taken; a stalled rsp_ready holds the block. Reset loads
// register defaults.
module wall_follow_drive_controller_core #(
   parameter int RANGE_BITS      = 14,
   parameter int TICK_COUNT_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [RANGE_BITS-1:0]   req_front_range_mm,
   input  logic [RANGE_BITS-1:0]   req_near_ray_mm,
   input  logic [RANGE_BITS-1:0]   req_far_ray_mm,
   input  logic                    req_marker_seen,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [7:0]              rsp_linear_mm_per_s,
   output logic signed [10:0]      rsp_angular_mrad_per_s,
   output logic                    rsp_finished_pulse,
   output logic [1:0]              rsp_drive_state,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [3:0]              csr_index,
   input  logic [15:0]             csr_data
);
   import wfdc_pkg::*;

   localparam int RB  = RANGE_BITS;
   localparam int CW  = (RB > CFG_W) ? RB : CFG_W;
   localparam int DW  = 2 * RB + 18;
   localparam int RW  = DW / 2;
   localparam int QW  = 2 * RB + 7;
   localparam int SW  = QW + 2;
   localparam int TW  = TICK_COUNT_BITS;
   localparam int CTW = (TW > TMO_W) ? TW : TMO_W;
   localparam int MAW = 2 * RB;
   localparam int MBW = (RB > 17) ? RB : 17;
   localparam int MPW = MAW + MBW;
   localparam int SPW = MAG_W + RECIP_W;

   // configuration registers
   logic [CFG_W-1:0] clearance_ff, band_half_ff, hyst_margin_ff;
   logic [CFG_W-1:0] nose_stop_ff, nose_clear_ff, side_near_ff, gap_min_ff;
   logic [TMO_W-1:0] corner_tmo_ff;

   // controller state
   logic                finish_latched_ff, finish_latched_in;
   logic                finish_announced_ff, finish_announced_in;
   drive_mode_type      mode_ff, mode_in;
   logic [TW-1:0]       tick_cnt_ff, tick_cnt_in;
   logic [OPEN_W-1:0]   open_cnt_ff, open_cnt_in;
   band_type            band_ff, band_in;

   // request and sequencer
   seq_state_type       st_ff, st_in;
   logic [RB-1:0]       front_ff, rn_ff, rf_ff;
   logic                marker_ff;
   logic [1:0]          step_ff;
   logic [MAW-1:0]      sq_n_ff, sq_f_ff, p_nf_ff;
   logic [MPW-1:0]      k_ff;
   logic [SPW-1:0]      scale_ff;

   // response registers
   logic [7:0]          lin_ff, lin_in;
   logic signed [10:0]  ang_ff, ang_in;
   logic                pulse_ff, pulse_in;
   logic [1:0]          dst_ff, dst_in;

   logic                req_acc, skip, root_start, div_start, cordic_start;
   logic                root_done, div_done;
   logic [MAW-1:0]      mul_a;
   logic [MBW-1:0]      mul_b;
   logic [MPW-1:0]      mul_p;
   logic [DW-1:0]       d2;
   logic [RW-1:0]       root;
   logic [QW-1:0]       quo, dperp;
   logic signed [RB:0]  diff;
   logic signed [TH_W-1:0] theta;
   logic [TH_W-2:0]     atheta;
   logic [MAG_W-1:0]    mag_v;

   assign req_acc = req_valid && req_ready;
   assign skip    = req_marker_seen || finish_latched_ff ||
                    (req_near_ray_mm == '0) || (req_far_ray_mm == '0);

   // configuration writes
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         clearance_ff    <= 14'd400;
         band_half_ff    <= 14'd100;
         hyst_margin_ff  <= 14'd30;
         nose_stop_ff    <= 14'd320;
         nose_clear_ff   <= 14'd450;
         side_near_ff    <= 14'd800;
         gap_min_ff      <= 14'd1100;
         corner_tmo_ff   <= 16'd700;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_CLEARANCE:    clearance_ff    <= csr_data[CFG_W-1:0];
            CSR_BAND_HALF:    band_half_ff    <= csr_data[CFG_W-1:0];
            CSR_HYST_MARGIN:  hyst_margin_ff  <= csr_data[CFG_W-1:0];
            CSR_NOSE_STOP:    nose_stop_ff    <= csr_data[CFG_W-1:0];
            CSR_NOSE_CLEAR:   nose_clear_ff   <= csr_data[CFG_W-1:0];
            CSR_SIDE_NEAR:    side_near_ff    <= csr_data[CFG_W-1:0];
            CSR_GAP_MIN:      gap_min_ff      <= csr_data[CFG_W-1:0];
            CSR_CORNER_TMO:   corner_tmo_ff   <= csr_data[TMO_W-1:0];
            default: ;
         endcase
      end
   end

   // sequencer next state
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_IDLE:    if (req_acc) st_in = skip ? ST_DECIDE : ST_MUL;
         ST_MUL:     if (step_ff == 2'd3) st_in = ST_ROOT_GO;
         ST_ROOT_GO: st_in = ST_ROOT;
         ST_ROOT:    if (root_done) st_in = ST_DIV_GO;
         ST_DIV_GO:  st_in = ST_DIV;
         ST_DIV:     if (div_done) st_in = ST_SCALE;
         ST_SCALE:   st_in = ST_DECIDE;
         ST_DECIDE:  st_in = ST_RESP;
         ST_RESP:    if (rsp_ready) st_in = ST_IDLE;
         default:    st_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready    = (st_ff == ST_IDLE);
      rsp_valid    = (st_ff == ST_RESP);
      root_start   = (st_ff == ST_ROOT_GO);
      div_start    = (st_ff == ST_DIV_GO);
      cordic_start = (st_ff == ST_ROOT_GO);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= ST_IDLE;
         step_ff <= '0;
      end else begin
         st_ff   <= st_in;
         step_ff <= (st_ff == ST_MUL) ? step_ff + 1'b1 : 2'd0;
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (req_acc) begin
         front_ff  <= req_front_range_mm;
         rn_ff     <= req_near_ray_mm;
         rf_ff     <= req_far_ray_mm;
         marker_ff <= req_marker_seen;
      end
   end

   // shared multiplier: rn^2, rf^2, rn*rf, then rn*rf*2cos30
   always_comb begin
      case (step_ff)
         2'd0:    begin mul_a = MAW'(rn_ff);   mul_b = MBW'(rn_ff); end
         2'd1:    begin mul_a = MAW'(rf_ff);   mul_b = MBW'(rf_ff); end
         2'd2:    begin mul_a = MAW'(rn_ff);   mul_b = MBW'(rf_ff); end
         default: begin mul_a = p_nf_ff;       mul_b = MBW'(COS30_Q16X2); end
      endcase
      mul_p = MPW'(mul_a) * MPW'(mul_b);
   end

   always_ff @(posedge clock) begin
      if (st_ff == ST_MUL) begin
         case (step_ff)
            2'd0:    sq_n_ff <= mul_p[MAW-1:0];
            2'd1:    sq_f_ff <= mul_p[MAW-1:0];
            2'd2:    p_nf_ff <= mul_p[MAW-1:0];
            default: k_ff    <= mul_p;
         endcase
      end
   end

   assign d2 = ((DW'(sq_n_ff) + DW'(sq_f_ff)) << 16) - DW'(k_ff);

   wfdc_sqrt #(.VAL_W(DW)) u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (root_start),
      .value (d2),
      .root  (root),
      .done  (root_done)
   );

   wfdc_div #(.NUM_W(QW), .DEN_W(RW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (QW'(p_nf_ff) << 7),
      .denom    (root),
      .quotient (quo),
      .done     (div_done)
   );

   assign diff = signed'({1'b0, rn_ff}) - signed'({1'b0, rf_ff});

   wfdc_cordic #(.DIFF_W(RB + 1)) u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cordic_start),
      .diff  (diff),
      .theta (theta)
   );

   // perpendicular distance, heading magnitude, align turn rate numerator
   always_comb begin
      if (root == '0) begin
         dperp = (rn_ff < rf_ff) ? QW'(rn_ff) : QW'(rf_ff);
      end else begin
         dperp = quo;
      end
      atheta = theta[TH_W-1] ? (TH_W-1)'(-theta) : theta[TH_W-2:0];
      mag_v  = MAG_W'(atheta) * MAG_W'(12) + ROUND_5000;
   end

   // reciprocal product for the divide by 10000
   always_ff @(posedge clock) begin
      if (st_ff == ST_SCALE) begin
         scale_ff <= SPW'(mag_v) * SPW'(RECIP_10000);
      end
   end

   // per-tick decision
   always_comb begin
      logic [11:0]          q_est;
      logic [MAG_W-1:0]     q_rem;
      logic [11:0]          q_fix;
      logic [9:0]           mag;
      logic [TW-1:0]        cnt_inc;
      logic                 present;
      logic                 opening;
      logic signed [SW-1:0] sd, tgt, bw, inner;

      q_est   = scale_ff[RECIP_SH +: 12];
      q_rem   = mag_v - MAG_W'(q_est) * DEC_10000;
      q_fix   = (q_rem >= DEC_10000) ? q_est + 1'b1 : q_est;
      mag     = (mag_v >= MAG_LIMIT_V) ? ANG_MAX : q_fix[9:0];
      cnt_inc = (tick_cnt_ff == '1) ? tick_cnt_ff : tick_cnt_ff + 1'b1;
      present = (CW'(rn_ff) < CW'(side_near_ff)) && (CW'(rf_ff) < CW'(side_near_ff));
      opening = (CW'(rn_ff) > CW'(gap_min_ff)) || (CW'(rf_ff) > CW'(gap_min_ff));
      sd      = signed'(SW'(dperp));
      tgt     = signed'(SW'(clearance_ff));
      bw      = signed'(SW'(band_half_ff));
      inner   = bw - signed'(SW'(hyst_margin_ff));

      finish_latched_in   = finish_latched_ff;
      finish_announced_in = finish_announced_ff;
      mode_in             = mode_ff;
      tick_cnt_in         = tick_cnt_ff;
      open_cnt_in         = open_cnt_ff;
      band_in             = band_ff;
      lin_in              = LIN_STOP;
      ang_in              = ANG_ZERO;
      pulse_in            = 1'b0;
      dst_in              = mode_ff;

      if (marker_ff || finish_latched_ff) begin
         // finished: stop for good, pulse once
         finish_latched_in   = 1'b1;
         finish_announced_in = 1'b1;
         pulse_in            = !finish_announced_ff;
         dst_in              = MODE_FINISHED;
      end else if ((rn_ff == '0) || (rf_ff == '0)) begin
         // invalid ray: search turn, only the tick count moves
         tick_cnt_in = cnt_inc;
         ang_in      = ANG_SEARCH;
      end else begin
         tick_cnt_in = cnt_inc;
         if (opening) begin
            if (open_cnt_ff < OPEN_SAT) open_cnt_in = open_cnt_ff + 1'b1;
         end else if (present) begin
            open_cnt_in = '0;
         end

         if (mode_ff != MODE_AVOID && CW'(front_ff) < CW'(nose_stop_ff)) begin
            mode_in     = MODE_AVOID;
            tick_cnt_in = '0;
         end

         if (mode_in == MODE_AVOID) begin
            if (CW'(front_ff) > CW'(nose_clear_ff)) begin
               mode_in     = MODE_TRACK;
               tick_cnt_in = '0;
               lin_in      = LIN_AVOID;
            end else begin
               ang_in = ANG_SPIN;
            end
         end else if (mode_in == MODE_CORNER) begin
            if ((present && atheta < TOL_REACQ) ||
                (CTW'(tick_cnt_in) > CTW'(corner_tmo_ff))) begin
               mode_in     = MODE_TRACK;
               tick_cnt_in = '0;
               lin_in      = LIN_FULL;
            end else begin
               lin_in = LIN_CORNER;
               ang_in = ANG_CORNER;
            end
         end else begin
            mode_in = MODE_TRACK;
            if (open_cnt_in >= 7'd2 && rn_ff >= rf_ff) begin
               // corner entry round an opening
               mode_in     = MODE_CORNER;
               tick_cnt_in = '0;
               lin_in      = LIN_CORNER;
               ang_in      = ANG_CORNER;
            end else if (atheta > TOL_PARALLEL) begin
               // align in place
               ang_in = theta[TH_W-1] ? signed'(11'(mag)) : -signed'(11'(mag));
            end else begin
               // distance band with hysteresis
               case (band_ff)
                  BAND_CLOSE: if (sd >= tgt - inner) band_in = BAND_IN;
                  BAND_FAR:   if (sd <= tgt + inner) band_in = BAND_IN;
                  default: begin
                     band_in = BAND_IN;
                     if (sd < tgt - bw)      band_in = BAND_CLOSE;
                     else if (sd > tgt + bw) band_in = BAND_FAR;
                  end
               endcase
               case (band_in)
                  BAND_CLOSE: begin lin_in = LIN_BAND; ang_in = ANG_AWAY; end
                  BAND_FAR:   begin lin_in = LIN_BAND; ang_in = ANG_TOWARD; end
                  default:    begin lin_in = LIN_FULL; ang_in = ANG_ZERO; end
               endcase
            end
         end
         dst_in = mode_in;
      end
   end

   // state and response update
   always_ff @(posedge clock) begin
      if (reset) begin
         finish_latched_ff   <= 1'b0;
         finish_announced_ff <= 1'b0;
         mode_ff             <= MODE_TRACK;
         tick_cnt_ff         <= '0;
         open_cnt_ff         <= '0;
         band_ff             <= BAND_IN;
      end else if (st_ff == ST_DECIDE) begin
         finish_latched_ff   <= finish_latched_in;
         finish_announced_ff <= finish_announced_in;
         mode_ff             <= mode_in;
         tick_cnt_ff         <= tick_cnt_in;
         open_cnt_ff         <= open_cnt_in;
         band_ff             <= band_in;
      end
   end

   always_ff @(posedge clock) begin
      if (st_ff == ST_DECIDE) begin
         lin_ff   <= lin_in;
         ang_ff   <= ang_in;
         pulse_ff <= pulse_in;
         dst_ff   <= dst_in;
      end
   end

   assign rsp_linear_mm_per_s    = lin_ff;
   assign rsp_angular_mrad_per_s = ang_ff;
   assign rsp_finished_pulse     = pulse_ff;
   assign rsp_drive_state        = dst_ff;
endmodule
